[hw/rtl/utf8_column_text_wrap_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the UTF-8 column wrap core
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef UTF8_COLUMN_TEXT_WRAP_CORE_MACROS_SVH
`define UTF8_COLUMN_TEXT_WRAP_CORE_MACROS_SVH

// Same-cycle implication
`define UCW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define UCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/ucw_pkg.sv]
// ----------------------------------------------------------------------------
// ucw_pkg
// Types, constants and helpers for the UTF-8 column wrap core.
// ----------------------------------------------------------------------------
`default_nettype none

package ucw_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned MAXW_W   = 8;
    localparam int unsigned TABW_W   = 5;
    localparam int unsigned COL_W    = 9;
    localparam int unsigned ROW_W    = 16;
    localparam int unsigned CNT_W    = 24;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] CHR_NUL = 8'h00;
    localparam logic [BYTE_W-1:0] CHR_TAB = 8'h09;
    localparam logic [BYTE_W-1:0] CHR_LF  = 8'h0A;
    // top two bits of a continuation byte
    localparam logic [1:0]        CONT_TAG = 2'b10;

    localparam logic [COL_W-1:0]  COL_MAX = '1;
    localparam logic [ROW_W-1:0]  ROW_MAX = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_WRAP_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAB_STEP   = 2'd1;

    localparam logic [MAXW_W-1:0] WRAP_LIMIT_RST = 8'd0;
    localparam logic [TABW_W-1:0] TAB_STEP_RST   = 5'd1;
    localparam logic [ROW_W-1:0]  ROWS_RST       = 16'd1;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        logic [ROW_W-1:0]  rows;
        logic [CNT_W-1:0]  cps;
        logic [CNT_W-1:0]  bytes;
    } t_result;

    function automatic logic [ROW_W-1:0] sat_inc_row(input logic [ROW_W-1:0] v);
        return (v == ROW_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc_cnt(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/utf8_column_text_wrap_core.sv]
// A result is registered: in the skid entry if the output register is stalled.
// One byte per cycle while the skid entry is free; a byte that needs an
// inserted newline is held off while the newline goes out first.
// The output register plus one skid entry decouple the input from o_out ready.
// Reset (synchronous, i_rst_n low) clears codepoint and byte counts, column,
// hold flag and valids, sets rows to 1, loads wrap limit 0 and tab step 1.
// ----------------------------------------------------------------------------
// utf8_column_text_wrap_core
// Hard line wrap at a configurable column (wrap limit 0 disables it) over a
// UTF-8 byte stream with running row, codepoint and byte counts.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_column_text_wrap_core_macros.svh"

module utf8_column_text_wrap_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [ucw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [ucw_pkg::BYTE_W-1:0]         i_cfg_data,
    // input bytes
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [ucw_pkg::BYTE_W-1:0]         i_in_byte,
    // results
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [ucw_pkg::BYTE_W-1:0]              o_out_byte,
    output logic                                    o_last_of_run,
    output logic [ucw_pkg::ROW_W-1:0]               o_row_count,
    output logic [ucw_pkg::CNT_W-1:0]               o_codepoint_count,
    output logic [ucw_pkg::CNT_W-1:0]               o_byte_count
);

    logic [ucw_pkg::MAXW_W-1:0] r_wrap_limit;
    logic [ucw_pkg::TABW_W-1:0] r_tab_step;

    logic [ucw_pkg::COL_W-1:0]  r_column, n_column;
    logic [ucw_pkg::ROW_W-1:0]  r_rows, n_rows;
    logic [ucw_pkg::CNT_W-1:0]  r_cps, n_cps;
    logic [ucw_pkg::CNT_W-1:0]  r_bytes, n_bytes;
    logic                       r_wrap_done, n_wrap_done;

    ucw_pkg::t_result r_out, r_skid, n_res;
    logic             r_out_valid, r_skid_valid;

    logic             w_is_term, w_is_cont, w_is_lf, w_is_tab, w_insert, w_produce;
    logic [ucw_pkg::COL_W:0] w_col_sum;

    // ---------------------------------------------------------------- config
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_limit <= ucw_pkg::WRAP_LIMIT_RST;
            r_tab_step   <= ucw_pkg::TAB_STEP_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ucw_pkg::REG_WRAP_LIMIT: r_wrap_limit <= i_cfg_data;
                ucw_pkg::REG_TAB_STEP:   r_tab_step <= i_cfg_data[ucw_pkg::TABW_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------ byte decode
    assign w_is_term = (i_in_byte == ucw_pkg::CHR_NUL);
    assign w_is_cont = (i_in_byte[7:6] == ucw_pkg::CONT_TAG);
    assign w_is_lf   = (i_in_byte == ucw_pkg::CHR_LF);
    assign w_is_tab  = (i_in_byte == ucw_pkg::CHR_TAB);

    // A held byte that already got its newline must not wrap again.
    assign w_insert = !w_is_term && !w_is_cont && !w_is_lf && !r_wrap_done
                    && (r_wrap_limit != '0)
                    && (r_column >= {1'b0, r_wrap_limit});

    // a result is produced whenever the input is valid and the skid is free
    assign w_produce  = i_in_valid && !r_skid_valid;
    assign o_in_ready = !r_skid_valid && !w_insert;

    assign w_col_sum = {1'b0, r_column}
                     + (w_is_tab ? (ucw_pkg::COL_W+1)'(r_tab_step)
                                 : (ucw_pkg::COL_W+1)'(1));

    always_comb begin
        n_column    = r_column;
        n_rows      = r_rows;
        n_cps       = r_cps;
        n_bytes     = ucw_pkg::sat_inc_cnt(r_bytes);
        n_wrap_done = 1'b0;
        n_res.out_byte = i_in_byte;
        n_res.last     = 1'b1;

        if (w_insert) begin
            n_rows         = ucw_pkg::sat_inc_row(r_rows);
            n_cps          = ucw_pkg::sat_inc_cnt(r_cps);
            n_column       = ucw_pkg::COL_W'(1);
            n_wrap_done    = 1'b1;
            n_res.out_byte = ucw_pkg::CHR_LF;
            n_res.last     = 1'b0;
        end else if (!w_is_term && !w_is_cont) begin
            n_cps = ucw_pkg::sat_inc_cnt(r_cps);
            if (w_is_lf) begin
                n_rows   = ucw_pkg::sat_inc_row(r_rows);
                n_column = '0;
            end else if (r_wrap_done) begin
                // byte after its inserted newline sits in column 1, no advance
                n_column = r_column;
            end else if (w_col_sum > (ucw_pkg::COL_W+1)'(ucw_pkg::COL_MAX)) begin
                n_column = ucw_pkg::COL_MAX;
            end else begin
                n_column = w_col_sum[ucw_pkg::COL_W-1:0];
            end
        end

        n_res.rows  = n_rows;
        n_res.cps   = n_cps;
        n_res.bytes = n_bytes;

        // terminator: result counts it in bytes only, then state restarts
        if (w_is_term) begin
            n_column = '0;
            n_rows   = ucw_pkg::ROWS_RST;
            n_cps    = '0;
            n_bytes  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column    <= '0;
            r_rows      <= ucw_pkg::ROWS_RST;
            r_cps       <= '0;
            r_bytes     <= '0;
            r_wrap_done <= 1'b0;
        end else if (w_produce) begin
            r_column    <= n_column;
            r_rows      <= n_rows;
            r_cps       <= n_cps;
            r_bytes     <= n_bytes;
            r_wrap_done <= n_wrap_done;
        end
    end

    // ------------------------------------------------- output register + skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_produce) begin
            if (!r_out_valid || i_out_ready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (i_out_ready) begin
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_produce) begin
            if (!r_out_valid || i_out_ready) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end else if (i_out_ready && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_byte        = r_out.out_byte;
    assign o_last_of_run     = r_out.last;
    assign o_row_count       = r_out.rows;
    assign o_codepoint_count = r_out.cps;
    assign o_byte_count      = r_out.bytes;

    // ------------------------------------------------------------ assertions
    `UCW_ASSERT_NOW(a_skid_needs_out, r_skid_valid, r_out_valid,
        "skid entry held while output register empty")
    `UCW_ASSERT_NEXT(a_insert_marks_hold, w_produce && w_insert, r_wrap_done,
        "inserted newline did not mark the held byte")
    `UCW_ASSERT_NEXT(a_accept_clears_hold, i_in_valid && o_in_ready, !r_wrap_done,
        "hold flag survived a byte transfer")
    `UCW_ASSERT_NOW(a_nonlast_is_lf, r_out_valid && !r_out.last,
        r_out.out_byte == ucw_pkg::CHR_LF,
        "non-final result is not an inserted newline")
    `UCW_ASSERT_NOW(a_rows_nonzero, 1'b1, r_rows != '0,
        "row count dropped to zero")

endmodule

`default_nettype wire
